@@ hdl/bdlp_pkg.sv @@
// Package for the button debouncer with long-press detection.
// Holds sizes, register map, event codes and the controller/datapath structs.
// No dependencies.
package bdlp_pkg;

	// Sizes
	localparam int NUM_BUTTONS = 4;
	localparam int COUNT_WIDTH = 8;
	localparam int BTN_W       = $clog2(NUM_BUTTONS);
	localparam int LEVEL_W     = 4;
	localparam int IDX_W       = 2;
	localparam int CODE_W      = 3;
	localparam int TIME_W      = 32;
	localparam int DBC_W       = 8;
	localparam int MAX_RESULTS = 8;
	localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	// APB register map
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam logic [1:0] REG_DEBOUNCE_COUNT = 2'd0;
	localparam logic [1:0] REG_LONG_PRESS_MS  = 2'd1;
	localparam logic [1:0] REG_VLONG_PRESS_MS = 2'd2;

	// Register reset values
	localparam logic [DBC_W-1:0]  RST_DEBOUNCE_COUNT = 8'd5;
	localparam logic [TIME_W-1:0] RST_LONG_PRESS_MS  = 32'd1000;
	localparam logic [TIME_W-1:0] RST_VLONG_PRESS_MS = 32'd3000;

	// Event codes
	typedef enum logic [CODE_W-1:0] {
		EV_PRESSED        = 3'd0,
		EV_SHORT_RELEASE  = 3'd1,
		EV_LONG_RELEASE   = 3'd2,
		EV_VLONG_RELEASE  = 3'd3,
		EV_HOLDING_LONG   = 3'd4,
		EV_HOLDING_VLONG  = 3'd5
	} bdlp_event_t;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [DBC_W-1:0]  debounce_count;
		logic [TIME_W-1:0] long_press_ms;
		logic [TIME_W-1:0] very_long_press_ms;
	} bdlp_cfg_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_in;
		logic diff;
		logic eval;
		logic emit;
		logic next_btn;
		logic flush;
	} bdlp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic mask_empty;
		logic emit_ok;
		logic pend_valid;
		logic can_push;
		logic last_btn;
	} bdlp_sts_t;

endpackage

@@ hdl/bdlp_if.sv @@
// Valid/ready channel interfaces for poll ticks and events.
// Depends on bdlp_pkg for field widths.
interface bdlp_in_if import bdlp_pkg::*;;
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] button_levels;
	logic [TIME_W-1:0]  now_ms;

	modport source (output valid, output button_levels, output now_ms, input ready);
	modport sink   (input valid, input button_levels, input now_ms, output ready);
endinterface

interface bdlp_out_if import bdlp_pkg::*;;
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  button_index;
	logic [CODE_W-1:0] event_code;
	logic              last_of_tick;

	modport source (output valid, output button_index, output event_code,
		output last_of_tick, input ready);
	modport sink   (input valid, input button_index, input event_code,
		input last_of_tick, output ready);
endinterface

@@ hdl/button_debounce_long_press.sv @@
// Integrating debouncer for four buttons with press, release-class and hold events.
// The sequencer visits each button in turn (elapsed-time subtract, evaluate,
// drain) through one shared 32-bit subtract and compare path, and events leave
// through a single output register, so a stalled sink adds cycles. At most
// eight events leave per tick. Ticks wait for the previous one to finish, while
// the last event may still sit in the output register. Events come in button
// order; last_of_tick marks the final event of a tick, and a tick without events
// produces nothing. Configuration is over APB at byte addresses 0, 4 and 8.
module button_debounce_long_press import bdlp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	bdlp_in_if.sink            in_ch,
	bdlp_out_if.source         out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	bdlp_cfg_t cfg;
	bdlp_cmd_t cmd;
	bdlp_sts_t sts;

	bdlp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bdlp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bdlp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_levels (in_ch.button_levels),
		.in_now    (in_ch.now_ms),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.out_ch    (out_ch)
	);

endmodule

@@ hdl/bdlp_regs.sv @@
// APB configuration registers: debounce count and the two hold thresholds.
// Depends on bdlp_pkg for the register map and reset values.
module bdlp_regs import bdlp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output bdlp_cfg_t          cfg
);

	logic [DBC_W-1:0]  dbc_q;
	logic [TIME_W-1:0] long_q;
	logic [TIME_W-1:0] vlong_q;
	logic [1:0]        reg_idx;
	logic              wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbc_q   <= RST_DEBOUNCE_COUNT;
			long_q  <= RST_LONG_PRESS_MS;
			vlong_q <= RST_VLONG_PRESS_MS;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DEBOUNCE_COUNT: dbc_q   <= pwdata[DBC_W-1:0];
				REG_LONG_PRESS_MS:  long_q  <= pwdata[TIME_W-1:0];
				REG_VLONG_PRESS_MS: vlong_q <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_DEBOUNCE_COUNT: prdata = {{(PDATA_W-DBC_W){1'b0}}, dbc_q};
			REG_LONG_PRESS_MS:  prdata = long_q;
			REG_VLONG_PRESS_MS: prdata = vlong_q;
			default:            prdata = '0;
		endcase
	end

	assign cfg.debounce_count     = dbc_q;
	assign cfg.long_press_ms      = long_q;
	assign cfg.very_long_press_ms = vlong_q;

endmodule

@@ hdl/bdlp_ctrl.sv @@
// Sequencer that walks the buttons of one poll tick and drains its events.
// Depends on bdlp_pkg for the command and status structs.
module bdlp_ctrl import bdlp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  bdlp_sts_t sts,
	output bdlp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIFF,
		S_EVAL,
		S_EMIT,
		S_FLUSH
	} state_t;

	state_t state_q;

	// Hold state and advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DIFF;
				end
				S_DIFF: state_q <= S_EVAL;
				S_EVAL: state_q <= S_EMIT;
				S_EMIT: begin
					if (sts.mask_empty) begin
						state_q <= sts.last_btn ? S_FLUSH : S_DIFF;
					end
				end
				S_FLUSH: begin
					if (!sts.pend_valid || sts.can_push) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Decode commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			S_DIFF: cmd.diff = 1'b1;
			S_EVAL: cmd.eval = 1'b1;
			S_EMIT: begin
				cmd.emit     = !sts.mask_empty && sts.emit_ok;
				cmd.next_btn = sts.mask_empty && !sts.last_btn;
			end
			S_FLUSH: cmd.flush = sts.pend_valid && sts.can_push;
			default: ;
		endcase
	end

endmodule

@@ hdl/bdlp_dp.sv @@
// Datapath: per-button debounce state, elapsed-time subtract, event staging
// and the output register. Depends on bdlp_pkg and the output channel interface.
module bdlp_dp import bdlp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [LEVEL_W-1:0] in_levels,
	input  logic [TIME_W-1:0]  in_now,
	input  bdlp_cfg_t          cfg,
	input  bdlp_cmd_t          cmd,
	output bdlp_sts_t          sts,
	bdlp_out_if.source         out_ch
);

	// Per-button state
	logic [COUNT_WIDTH-1:0] cnt_q   [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] pr_q;
	logic [NUM_BUTTONS-1:0] ln_q;
	logic [NUM_BUTTONS-1:0] vln_q;
	logic [TIME_W-1:0]      start_q [NUM_BUTTONS];

	// Tick context
	logic [LEVEL_W-1:0] levels_q;
	logic [TIME_W-1:0]  now_q;
	logic [BTN_W-1:0]   btn_q;
	logic [TIME_W-1:0]  d_q;

	// Events of the current button: bit 0 press/release, 1 hold long, 2 hold very long
	logic [2:0]        mask_q;
	logic [CODE_W-1:0] code0_q;

	// Staged event and output register
	logic              pend_valid_q;
	logic [BTN_W-1:0]  pend_btn_q;
	logic [CODE_W-1:0] pend_code_q;
	logic [NCNT_W-1:0] n_q;
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [CODE_W-1:0] out_code_q;
	logic              out_last_q;

	// Evaluation of the current button
	logic                   level;
	logic [COUNT_WIDTH-1:0] cnt;
	logic [COUNT_WIDTH-1:0] cnt_n;
	logic                   pr_n;
	logic                   ln_n;
	logic                   vln_n;
	logic                   press;
	logic                   release_ev;
	logic [CODE_W-1:0]      rel_code;
	logic [TIME_W-1:0]      d_hold;
	logic                   hl;
	logic                   hv;

	// Emit selection
	logic              full;
	logic              can_push;
	logic              push;
	logic [CODE_W-1:0] sel_code;
	logic [2:0]        sel_bit;

	assign level = levels_q[btn_q];
	assign cnt   = cnt_q[btn_q];

	// Step the counter and classify the transition
	always_comb begin
		cnt_n      = cnt;
		pr_n       = pr_q[btn_q];
		press      = 1'b0;
		release_ev = 1'b0;
		if (d_q > cfg.very_long_press_ms) begin
			rel_code = EV_VLONG_RELEASE;
		end else if (d_q > cfg.long_press_ms) begin
			rel_code = EV_LONG_RELEASE;
		end else begin
			rel_code = EV_SHORT_RELEASE;
		end
		if (level) begin
			if (cnt < cfg.debounce_count && cnt < COUNT_MAX) begin
				cnt_n = cnt + 1'b1;
				if (cnt_n >= cfg.debounce_count && !pr_q[btn_q]) begin
					pr_n  = 1'b1;
					press = 1'b1;
				end
			end
		end else if (cnt != '0) begin
			cnt_n = cnt - 1'b1;
			if (cnt_n == '0 && pr_q[btn_q]) begin
				pr_n       = 1'b0;
				release_ev = 1'b1;
			end
		end
	end

	// Hold notifications; a fresh press has zero elapsed time
	always_comb begin
		d_hold = press ? '0 : d_q;
		hl     = pr_n && !ln_q[btn_q] && (d_hold > cfg.long_press_ms);
		hv     = pr_n && !vln_q[btn_q] && (d_hold > cfg.very_long_press_ms);
		ln_n   = pr_n && (ln_q[btn_q] || hl);
		vln_n  = pr_n && (vln_q[btn_q] || hv);
	end

	// Update button state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++) cnt_q[i] <= '0;
			pr_q  <= '0;
			ln_q  <= '0;
			vln_q <= '0;
		end else if (cmd.eval) begin
			cnt_q[btn_q] <= cnt_n;
			pr_q[btn_q]  <= pr_n;
			ln_q[btn_q]  <= ln_n;
			vln_q[btn_q] <= vln_n;
		end
	end

	// Record press time
	always_ff @(posedge clk) begin
		if (cmd.eval && press) start_q[btn_q] <= now_q;
	end

	// Latch tick, subtract elapsed time, stage button events
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			levels_q <= in_levels;
			now_q    <= in_now;
		end
		if (cmd.diff) d_q <= now_q - start_q[btn_q];
		if (cmd.eval) code0_q <= press ? EV_PRESSED : rel_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btn_q  <= '0;
			mask_q <= '0;
		end else begin
			if (cmd.load_in) btn_q <= '0;
			else if (cmd.next_btn) btn_q <= btn_q + 1'b1;
			if (cmd.eval) mask_q <= {hv, hl, press || release_ev};
			else if (cmd.emit) mask_q <= mask_q & ~sel_bit;
		end
	end

	// Pick the lowest pending event of the button
	always_comb begin
		if (mask_q[0]) begin
			sel_bit  = 3'b001;
			sel_code = code0_q;
		end else if (mask_q[1]) begin
			sel_bit  = 3'b010;
			sel_code = EV_HOLDING_LONG;
		end else begin
			sel_bit  = 3'b100;
			sel_code = EV_HOLDING_VLONG;
		end
	end

	assign full     = n_q >= NCNT_W'(MAX_RESULTS);
	assign can_push = !out_valid_q || out_ch.ready;
	assign push     = (cmd.emit && !full && pend_valid_q) || cmd.flush;

	// Stage one event so the final one of the tick can be flagged
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			n_q          <= '0;
		end else begin
			if (cmd.load_in) begin
				n_q <= '0;
			end else if (cmd.emit && !full) begin
				pend_valid_q <= 1'b1;
				n_q          <= n_q + 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && !full) begin
			pend_btn_q  <= btn_q;
			pend_code_q <= sel_code;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_idx_q  <= IDX_W'(pend_btn_q);
			out_code_q <= pend_code_q;
			out_last_q <= cmd.flush;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.button_index = out_idx_q;
	assign out_ch.event_code   = out_code_q;
	assign out_ch.last_of_tick = out_last_q;

	assign sts.mask_empty = (mask_q == '0);
	assign sts.emit_ok    = full || !pend_valid_q || can_push;
	assign sts.pend_valid = pend_valid_q;
	assign sts.can_push   = can_push;
	assign sts.last_btn   = (btn_q == BTN_W'(NUM_BUTTONS - 1));

endmodule
